[rtl/tlq_pkg.sv]
package tlq_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int LOG_LEVELS = 10;
  localparam int LEVELS     = LOG_LEVELS + 1;
  localparam int EDGE_CAP   = MAX_NODES - 1;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(EDGE_CAP + 1);
  localparam int TW  = $clog2(MAX_NODES + 1);
  localparam int LW  = $clog2(LEVELS);
  localparam int JAW = $clog2(MAX_NODES * LEVELS);
  localparam int JDEPTH = MAX_NODES * LEVELS;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2
  } status_t;

  // query steps: roots of a and b, meet(a,b), root of s, meet(a,s), meet(b,s)
  typedef enum logic [2:0] {
    PH_RA, PH_RB, PH_UV, PH_RS, PH_US, PH_VS
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_CLR, S_ROOT_RD, S_ROOT_CHK, S_PL_BASE, S_PL_RD, S_PL_WR,
    S_PUSH, S_POP_CHK, S_POP_U, S_POP_LV, S_EDGE_TEST, S_EDGE_CHK, S_SEEN_CHK,
    S_Q_START, S_R_LV, S_M_LV, S_LIFT_RD, S_LIFT_WR, S_L_DONE, S_M_RD, S_M_CMP,
    S_M_FIN, S_M_FIN2, S_NEXT, S_FINISH
  } state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_ADD, OP_NOT_BUILT, OP_RANGE, OP_CLR_STEP, OP_SEEN_RD_ROOT,
    OP_IDX_INC, OP_BUILD_DONE, OP_PLACE_ROOT, OP_PLACE_CHILD, OP_PLACE_BASE,
    OP_PL_READ, OP_PL_WRITE, OP_PUSH, OP_POP_RD, OP_POP_U, OP_POP_LV, OP_EDGE_RD,
    OP_E_INC, OP_SEEN_RD_W, OP_R_LOAD, OP_R_K, OP_M_LOAD, OP_M_LV, OP_LIFT_READ,
    OP_I_DEC, OP_LIFT_TAKE, OP_M_I_INIT, OP_M_READ, OP_M_STEP, OP_SAVE_P,
    OP_SAVE_J, OP_SET_ONP, OP_PUSH_OUT
  } op_t;

  typedef struct packed {
    op_t    op;
    phase_t ph;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic add_bad;
    logic built;
    logic query_oor;
    logic out_free;
    logic seen;
    logic idx_last;
    logic top_zero;
    logic e_end;
    logic e_match;
    logic k_bit;
    logic i_zero;
    logic i_last;
    logic p_eq_q;
    logic roots_differ;
    logic s_elsewhere;
    logic from_root;
  } stat_t;

  function automatic logic is_meet(phase_t ph);
    return (ph == PH_UV) || (ph == PH_US) || (ph == PH_VS);
  endfunction

  // flat jump table address: node * LEVELS + level
  function automatic logic [JAW-1:0] jaddr(logic [NW-1:0] n, logic [LW-1:0] l);
    return JAW'(n) * JAW'(LEVELS) + JAW'(l);
  endfunction

endpackage

[rtl/tlq_if.sv]
interface tlq_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [tlq_pkg::NW-1:0] node_a;
  logic [tlq_pkg::NW-1:0] node_b;
  logic [tlq_pkg::NW-1:0] node_s;
  modport source(output valid, req_type, node_a, node_b, node_s, input ready);
  modport sink(input valid, req_type, node_a, node_b, node_s, output ready);
endinterface

interface tlq_out_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [tlq_pkg::NW-1:0] ancestor;
  logic                   on_path;
  logic                   same_tree;
  modport source(output valid, status, ancestor, on_path, same_tree, input ready);
  modport sink(input valid, status, ancestor, on_path, same_tree, output ready);
endinterface

[rtl/tree_lca_path_query_unit.sv]
// Channel   Dir  Handshake      Payload
// in_item   in   valid/ready    req_type, node_a, node_b, node_s
// out_item  out  valid/ready    status, ancestor, on_path, same_tree
// cfg       in   cfg_we         cfg_wdata (node_count)
//
// One item at a time; every item gives exactly one result item.
// A query runs up to six ancestor searches over the jump table's two read
// ports. A build clears the visited flags, then walks the forest: it places
// and pops each node, checks each root candidate and scans every edge for
// every node popped.
// Reset is synchronous, active low; it empties the edge store and drops the
// built tables. A result waits in the output register while out_item stalls.
module tree_lca_path_query_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  tlq_in_if.sink                 in_item,
  tlq_out_if.source              out_item,
  input  logic                   cfg_we,
  input  logic [tlq_pkg::CW-1:0] cfg_wdata
);
  import tlq_pkg::*;

  cmd_t cmd;
  stat_t st;
  logic in_ready, in_acc;

  // take an item only while the controller sits idle
  assign in_item.ready = in_ready;
  assign in_acc        = in_item.valid & in_ready;

  tlq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tlq_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_req_type   (in_item.req_type),
    .in_node_a     (in_item.node_a),
    .in_node_b     (in_item.node_b),
    .in_node_s     (in_item.node_s),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_item.ready),
    .out_valid     (out_item.valid),
    .out_status    (out_item.status),
    .out_ancestor  (out_item.ancestor),
    .out_on_path   (out_item.on_path),
    .out_same_tree (out_item.same_tree)
  );

  // an accepted item closes the input until its work is done
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_item.ready)
    else $error("input taken twice in a row");

  // an error result carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.status != ST_OK) |->
      (out_item.ancestor == '0 && !out_item.on_path && !out_item.same_tree))
    else $error("error result with payload");

  // nodes in different trees have no ancestor and no path
  a_split_trees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && !out_item.same_tree) |->
      (out_item.ancestor == '0 && !out_item.on_path))
    else $error("path reported across trees");

endmodule

[rtl/tlq_ctrl.sv]
module tlq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_acc,
  input  tlq_pkg::stat_t st,
  output logic           in_ready,
  output tlq_pkg::cmd_t  cmd
);
  import tlq_pkg::*;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_RA;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd.op    = OP_NONE;
    cmd.ph    = ph_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.req)
          REQ_ADD: begin
            cmd.op    = OP_ADD;
            state_nxt = S_FINISH;
          end
          REQ_BUILD: state_nxt = S_CLR;
          REQ_QUERY: begin
            priority if (!st.built) begin
              cmd.op    = OP_NOT_BUILT;
              state_nxt = S_FINISH;
            end else if (st.query_oor) begin
              cmd.op    = OP_RANGE;
              state_nxt = S_FINISH;
            end else begin
              ph_nxt    = PH_RA;
              state_nxt = S_Q_START;
            end
          end
          REQ_NONE: state_nxt = S_FINISH;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_CLR: begin
        cmd.op = OP_CLR_STEP;
        if (st.idx_last) state_nxt = S_ROOT_RD;
      end
      S_ROOT_RD: begin
        cmd.op    = OP_SEEN_RD_ROOT;
        state_nxt = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        priority if (!st.seen) begin
          cmd.op    = OP_PLACE_ROOT;
          state_nxt = S_PL_BASE;
        end else if (st.idx_last) begin
          cmd.op    = OP_BUILD_DONE;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_IDX_INC;
          state_nxt = S_ROOT_RD;
        end
      end
      S_PL_BASE: begin
        cmd.op    = OP_PLACE_BASE;
        state_nxt = S_PL_RD;
      end
      S_PL_RD: begin
        cmd.op    = OP_PL_READ;
        state_nxt = S_PL_WR;
      end
      S_PL_WR: begin
        cmd.op    = OP_PL_WRITE;
        state_nxt = st.i_last ? S_PUSH : S_PL_RD;
      end
      S_PUSH: begin
        cmd.op    = OP_PUSH;
        state_nxt = st.from_root ? S_POP_CHK : S_EDGE_TEST;
      end
      S_POP_CHK: begin
        priority if (!st.top_zero) begin
          cmd.op    = OP_POP_RD;
          state_nxt = S_POP_U;
        end else if (st.idx_last) begin
          cmd.op    = OP_BUILD_DONE;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_IDX_INC;
          state_nxt = S_ROOT_RD;
        end
      end
      S_POP_U: begin
        cmd.op    = OP_POP_U;
        state_nxt = S_POP_LV;
      end
      S_POP_LV: begin
        cmd.op    = OP_POP_LV;
        state_nxt = S_EDGE_TEST;
      end
      S_EDGE_TEST: begin
        if (st.e_end) begin
          state_nxt = S_POP_CHK;
        end else begin
          cmd.op    = OP_EDGE_RD;
          state_nxt = S_EDGE_CHK;
        end
      end
      S_EDGE_CHK: begin
        if (st.e_match) begin
          cmd.op    = OP_SEEN_RD_W;
          state_nxt = S_SEEN_CHK;
        end else begin
          cmd.op    = OP_E_INC;
          state_nxt = S_EDGE_TEST;
        end
      end
      S_SEEN_CHK: begin
        if (st.seen) begin
          cmd.op    = OP_E_INC;
          state_nxt = S_EDGE_TEST;
        end else begin
          cmd.op    = OP_PLACE_CHILD;
          state_nxt = S_PL_BASE;
        end
      end
      S_Q_START: begin
        if (is_meet(ph_r)) begin
          cmd.op    = OP_M_LOAD;
          state_nxt = S_M_LV;
        end else begin
          cmd.op    = OP_R_LOAD;
          state_nxt = S_R_LV;
        end
      end
      S_R_LV: begin
        cmd.op    = OP_R_K;
        state_nxt = S_LIFT_RD;
      end
      S_M_LV: begin
        cmd.op    = OP_M_LV;
        state_nxt = S_LIFT_RD;
      end
      S_LIFT_RD: begin
        priority if (st.k_bit) begin
          cmd.op    = OP_LIFT_READ;
          state_nxt = S_LIFT_WR;
        end else if (st.i_zero) begin
          state_nxt = S_L_DONE;
        end else begin
          cmd.op = OP_I_DEC;
        end
      end
      S_LIFT_WR: begin
        cmd.op    = OP_LIFT_TAKE;
        state_nxt = st.i_zero ? S_L_DONE : S_LIFT_RD;
      end
      S_L_DONE: begin
        if (is_meet(ph_r) && !st.p_eq_q) begin
          cmd.op    = OP_M_I_INIT;
          state_nxt = S_M_RD;
        end else begin
          cmd.op    = OP_SAVE_P;
          state_nxt = S_NEXT;
        end
      end
      S_M_RD: begin
        cmd.op    = OP_M_READ;
        state_nxt = S_M_CMP;
      end
      S_M_CMP: begin
        cmd.op    = OP_M_STEP;
        state_nxt = st.i_zero ? S_M_FIN : S_M_RD;
      end
      S_M_FIN: begin
        cmd.op    = OP_M_READ;
        state_nxt = S_M_FIN2;
      end
      S_M_FIN2: begin
        cmd.op    = OP_SAVE_J;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        state_nxt = S_Q_START;
        unique case (ph_r)
          PH_RA: ph_nxt = PH_RB;
          PH_RB: begin
            if (st.roots_differ) state_nxt = S_FINISH;
            else                 ph_nxt    = PH_UV;
          end
          PH_UV: ph_nxt = PH_RS;
          PH_RS: begin
            if (st.s_elsewhere) state_nxt = S_FINISH;
            else                ph_nxt    = PH_US;
          end
          PH_US: ph_nxt = PH_VS;
          PH_VS: begin
            cmd.op    = OP_SET_ONP;
            state_nxt = S_FINISH;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.op    = OP_PUSH_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/tlq_dpath.sv]
module tlq_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlq_pkg::cmd_t          cmd,
  output tlq_pkg::stat_t         st,
  input  logic [1:0]             in_req_type,
  input  logic [tlq_pkg::NW-1:0] in_node_a,
  input  logic [tlq_pkg::NW-1:0] in_node_b,
  input  logic [tlq_pkg::NW-1:0] in_node_s,
  input  logic                   cfg_we,
  input  logic [tlq_pkg::CW-1:0] cfg_wdata,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [tlq_pkg::NW-1:0] out_ancestor,
  output logic                   out_on_path,
  output logic                   out_same_tree
);
  import tlq_pkg::*;

  // stores
  logic [NW-1:0] edge_x_mem [EDGE_CAP];
  logic [NW-1:0] edge_y_mem [EDGE_CAP];
  logic [NW-1:0] jump_mem   [JDEPTH];
  logic [NW-1:0] level_mem  [MAX_NODES];
  logic [NW-1:0] stack_mem  [MAX_NODES];
  logic          seen_mem   [MAX_NODES];

  // control registers
  logic [CW-1:0] cnt_r;
  logic [EW-1:0] edges_r;
  logic          built_r;
  logic [TW-1:0] top_r;
  logic          out_valid_r;

  // working registers
  req_t          req_r;
  logic [NW-1:0] a_r, b_r, s_r;
  logic [NW-1:0] idx_r, e_r, w_r, par_r, lvl_r, anc_r, u_r, lvu_r;
  logic [NW-1:0] p_r, q_r;
  logic [LEVELS-1:0] k_r;
  logic [LW-1:0] i_r;
  logic          from_root_r;
  logic [NW-1:0] ra_r, rb_r, rs_r, uv_r, us_r, vs_r;
  status_t       res_status_r;
  logic [NW-1:0] res_anc_r;
  logic          res_onp_r, res_same_r;
  status_t       out_status_r;
  logic [NW-1:0] out_anc_r;
  logic          out_onp_r, out_same_r;

  // registered read data
  logic [NW-1:0] ex_q, ey_q, jq0, jq1, lv_q0, lv_q1, stack_q;
  logic          seen_q;

  // read/write address selection
  logic [JAW-1:0] jr0_addr, jr1_addr, jw_addr;
  logic [NW-1:0]  jw_data;
  logic           jw_en;
  logic [NW-1:0]  lr0_addr, seen_raddr, xsel, ysel, cand, save_val;
  logic [TW-1:0]  top_m1;
  logic           add_bad, e_match, seen_we, seen_wd;
  logic [CW-1:0]  cnt_clamp;

  assign top_m1 = top_r - TW'(1);

  always_comb begin
    unique case (cmd.ph)
      PH_RA, PH_UV, PH_US: xsel = a_r;
      PH_RB, PH_VS:        xsel = b_r;
      default:             xsel = s_r;
    endcase
    ysel = (cmd.ph == PH_UV) ? b_r : s_r;
  end

  assign cand = (ex_q == u_r) ? ey_q : ex_q;
  assign e_match = ({1'b0, ex_q} < cnt_r) && ({1'b0, ey_q} < cnt_r) &&
                   ((ex_q == u_r) || (ey_q == u_r));
  assign add_bad = (edges_r >= EW'(EDGE_CAP)) || ({1'b0, a_r} >= cnt_r) ||
                   ({1'b0, b_r} >= cnt_r);
  assign save_val = (cmd.op == OP_SAVE_J) ? jq0 : p_r;

  always_comb begin
    jr0_addr = jaddr(p_r, i_r);
    jr1_addr = jaddr(q_r, i_r);
    if (cmd.op == OP_PL_READ) jr0_addr = jaddr(anc_r, i_r - LW'(1));
    jw_en   = (cmd.op == OP_PLACE_BASE) || (cmd.op == OP_PL_WRITE);
    jw_addr = (cmd.op == OP_PLACE_BASE) ? jaddr(w_r, '0) : jaddr(w_r, i_r);
    jw_data = (cmd.op == OP_PLACE_BASE) ? par_r : jq0;
    unique case (cmd.op)
      OP_POP_U:           lr0_addr = stack_q;
      OP_R_LOAD, OP_M_LOAD: lr0_addr = xsel;
      default:            lr0_addr = p_r;
    endcase
    seen_raddr = (cmd.op == OP_SEEN_RD_W) ? cand : idx_r;
    seen_we    = (cmd.op == OP_CLR_STEP) || (cmd.op == OP_PLACE_BASE);
    seen_wd    = (cmd.op == OP_PLACE_BASE);
    priority if (cfg_wdata == '0)               cnt_clamp = CW'(1);
    else if (cfg_wdata > CW'(MAX_NODES))        cnt_clamp = CW'(MAX_NODES);
    else                                        cnt_clamp = cfg_wdata;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ADD && !add_bad) begin
      edge_x_mem[edges_r] <= a_r;
      edge_y_mem[edges_r] <= b_r;
    end
    ex_q <= edge_x_mem[e_r];
    ey_q <= edge_y_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (jw_en) jump_mem[jw_addr] <= jw_data;
    jq0 <= jump_mem[jr0_addr];
    jq1 <= jump_mem[jr1_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PLACE_BASE) level_mem[w_r] <= lvl_r;
    lv_q0 <= level_mem[lr0_addr];
    lv_q1 <= level_mem[ysel];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH && top_r < TW'(MAX_NODES)) stack_mem[top_r[NW-1:0]] <= w_r;
    stack_q <= stack_mem[top_m1[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[(cmd.op == OP_CLR_STEP) ? idx_r : w_r] <= seen_wd;
    seen_q <= seen_mem[seen_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CW'(MAX_NODES);
      edges_r     <= '0;
      built_r     <= 1'b0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_PUSH_OUT)  out_valid_r <= 1'b1;
      else if (out_ready)         out_valid_r <= 1'b0;
      if (cfg_we) begin
        cnt_r   <= cnt_clamp;
        built_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_ADD: begin
          if (!add_bad) begin
            edges_r <= edges_r + EW'(1);
            built_r <= 1'b0;
          end
        end
        OP_BUILD_DONE: built_r <= 1'b1;
        OP_PUSH:   if (top_r < TW'(MAX_NODES)) top_r <= top_r + TW'(1);
        OP_POP_RD: top_r <= top_m1;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        req_r        <= req_t'(in_req_type);
        a_r          <= in_node_a;
        b_r          <= in_node_b;
        s_r          <= in_node_s;
        idx_r        <= '0;
        res_status_r <= ST_OK;
        res_anc_r    <= '0;
        res_onp_r    <= 1'b0;
        res_same_r   <= 1'b0;
      end
      OP_ADD:       if (add_bad) res_status_r <= ST_RANGE;
      OP_NOT_BUILT: res_status_r <= ST_NOT_BUILT;
      OP_RANGE:     res_status_r <= ST_RANGE;
      OP_CLR_STEP:  idx_r <= st.idx_last ? '0 : idx_r + NW'(1);
      OP_IDX_INC:   idx_r <= idx_r + NW'(1);
      OP_PLACE_ROOT: begin
        w_r         <= idx_r;
        par_r       <= idx_r;
        lvl_r       <= '0;
        from_root_r <= 1'b1;
      end
      OP_PLACE_CHILD: begin
        par_r       <= u_r;
        lvl_r       <= lvu_r + NW'(1);
        from_root_r <= 1'b0;
      end
      OP_PLACE_BASE: begin
        anc_r <= par_r;
        i_r   <= LW'(1);
      end
      OP_PL_WRITE: begin
        anc_r <= jq0;
        i_r   <= i_r + LW'(1);
      end
      OP_PUSH:      e_r <= e_r + NW'(1);
      OP_POP_U: begin
        u_r <= stack_q;
        e_r <= '0;
      end
      OP_POP_LV:    lvu_r <= lv_q0;
      OP_E_INC:     e_r <= e_r + NW'(1);
      OP_SEEN_RD_W: w_r <= cand;
      OP_R_LOAD:    p_r <= xsel;
      OP_R_K: begin
        k_r <= LEVELS'(lv_q0);
        i_r <= LW'(LOG_LEVELS);
      end
      OP_M_LOAD: begin
        p_r <= xsel;
        q_r <= ysel;
      end
      OP_M_LV: begin
        i_r <= LW'(LOG_LEVELS);
        if (lv_q0 < lv_q1) begin
          p_r <= q_r;
          q_r <= p_r;
          k_r <= LEVELS'(lv_q1 - lv_q0);
        end else begin
          k_r <= LEVELS'(lv_q0 - lv_q1);
        end
      end
      OP_I_DEC:     i_r <= i_r - LW'(1);
      OP_LIFT_TAKE: begin
        p_r <= jq0;
        if (i_r != '0) i_r <= i_r - LW'(1);
      end
      OP_M_I_INIT:  i_r <= LW'(LOG_LEVELS);
      OP_M_STEP: begin
        if (jq0 != jq1) begin
          p_r <= jq0;
          q_r <= jq1;
        end
        if (i_r != '0) i_r <= i_r - LW'(1);
      end
      OP_SAVE_P, OP_SAVE_J: begin
        unique case (cmd.ph)
          PH_RA: ra_r <= save_val;
          PH_RB: rb_r <= save_val;
          PH_UV: begin
            uv_r       <= save_val;
            res_anc_r  <= save_val;
            res_same_r <= 1'b1;
          end
          PH_RS: rs_r <= save_val;
          PH_US: us_r <= save_val;
          default: vs_r <= save_val;
        endcase
      end
      OP_SET_ONP: res_onp_r <= (uv_r == s_r) || ((us_r == uv_r) && (vs_r == s_r)) ||
                               ((vs_r == uv_r) && (us_r == s_r));
      OP_PUSH_OUT: begin
        out_status_r <= res_status_r;
        out_anc_r    <= res_anc_r;
        out_onp_r    <= res_onp_r;
        out_same_r   <= res_same_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.req          = req_r;
    st.add_bad      = add_bad;
    st.built        = built_r;
    st.query_oor    = ({1'b0, a_r} >= cnt_r) || ({1'b0, b_r} >= cnt_r) ||
                      ({1'b0, s_r} >= cnt_r);
    st.out_free     = !out_valid_r || out_ready;
    st.seen         = seen_q;
    st.idx_last     = ({1'b0, idx_r} == cnt_r - CW'(1));
    st.top_zero     = (top_r == '0);
    st.e_end        = (e_r == edges_r);
    st.e_match      = e_match;
    st.k_bit        = k_r[i_r];
    st.i_zero       = (i_r == '0);
    st.i_last       = (i_r == LW'(LOG_LEVELS));
    st.p_eq_q       = (p_r == q_r);
    st.roots_differ = (ra_r != rb_r);
    st.s_elsewhere  = (rs_r != ra_r);
    st.from_root    = from_root_r;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_ancestor  = out_anc_r;
  assign out_on_path   = out_onp_r;
  assign out_same_tree = out_same_r;

endmodule

[verif/tb_tree_lca_path_query_unit.sv]
module tb_tree_lca_path_query_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tlq_pkg::*;

  typedef struct packed {
    req_t             req;
    logic [NW-1:0]    a;
    logic [NW-1:0]    b;
    logic [NW-1:0]    s;
  } lca_req_t;

  typedef struct packed {
    status_t          status;
    logic [NW-1:0]    ancestor;
    logic             on_path;
    logic             same_tree;
  } lca_res_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  tlq_in_if  in_item();
  tlq_out_if out_item();

  tree_lca_path_query_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the block's state: edge store, built tables and the count.
  logic [CW-1:0] shadow_count;
  int            edge_first [EDGE_CAP];
  int            edge_second[EDGE_CAP];
  int            edges_held;
  bit            tables_built;
  int            jump [MAX_NODES][LEVELS];
  int            depth[MAX_NODES];
  bit            visited[MAX_NODES];
  int            walk[MAX_NODES];

  lca_req_t pending_reqs[$];   // items waiting for the driver
  lca_res_t expected_res[$];   // results owed by the block, oldest first
  lca_req_t on_wire;

  int send_idle_pct;
  int recv_stall_pct;
  int pushed_n;
  int accepted_n;
  int checked_n;
  int errors;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int n_queries;
  int n_builds;
  int n_joined;

  function automatic int live_count();
    if (shadow_count == 0) return 1;
    if (shadow_count > MAX_NODES) return MAX_NODES;
    return int'(shadow_count);
  endfunction

  function automatic void place_node(int w, int parent, int lv);
    visited[w] = 1'b1;
    depth[w] = lv;
    jump[w][0] = parent;
    for (int i = 1; i < LEVELS; i++) jump[w][i] = jump[jump[w][i-1]][i-1];
  endfunction

  // Walk every tree from its lowest node; neighbours are scanned in load order.
  function automatic void build_tables(int cnt);
    int top;
    int u;
    int x;
    int y;
    int w;
    for (int n = 0; n < MAX_NODES; n++) visited[n] = 1'b0;
    for (int r = 0; r < cnt; r++) begin
      if (visited[r]) continue;
      place_node(r, r, 0);
      walk[0] = r;
      top = 1;
      while (top > 0) begin
        top = top - 1;
        u = walk[top];
        for (int e = 0; e < edges_held; e++) begin
          x = edge_first[e];
          y = edge_second[e];
          if (x >= cnt || y >= cnt) continue;
          if (x == u) w = y;
          else if (y == u) w = x;
          else continue;
          if (visited[w]) continue;
          place_node(w, u, depth[u] + 1);
          if (top < MAX_NODES) begin
            walk[top] = w;
            top = top + 1;
          end
        end
      end
    end
    tables_built = 1'b1;
  endfunction

  function automatic int climb(int u, int k);
    for (int i = LOG_LEVELS; i >= 0; i--) if ((k >> i) & 1) u = jump[u][i];
    return u;
  endfunction

  function automatic int common_ancestor(int u, int v);
    int t;
    if (depth[u] < depth[v]) begin
      t = u; u = v; v = t;
    end
    u = climb(u, depth[u] - depth[v]);
    if (u == v) return u;
    for (int i = LOG_LEVELS; i >= 0; i--) begin
      if (jump[u][i] != jump[v][i]) begin
        u = jump[u][i];
        v = jump[v][i];
      end
    end
    return jump[u][0];
  endfunction

  function automatic int tree_root(int u);
    return climb(u, depth[u]);
  endfunction

  // Apply one accepted item to the shadow state and return the result it owes.
  function automatic lca_res_t answer_request(lca_req_t r);
    lca_res_t res;
    int cnt;
    int uv;
    int us;
    int vs;
    res = '{status: ST_OK, ancestor: '0, on_path: 1'b0, same_tree: 1'b0};
    cnt = live_count();
    case (r.req)
      REQ_ADD: begin
        if (edges_held >= EDGE_CAP || r.a >= cnt || r.b >= cnt) begin
          res.status = ST_RANGE;
        end else begin
          edge_first[edges_held] = r.a;
          edge_second[edges_held] = r.b;
          edges_held++;
          tables_built = 1'b0;
        end
      end
      REQ_BUILD: begin
        build_tables(cnt);
        n_builds++;
      end
      REQ_QUERY: begin
        n_queries++;
        if (!tables_built) begin
          res.status = ST_NOT_BUILT;
        end else if (r.a >= cnt || r.b >= cnt || r.s >= cnt) begin
          res.status = ST_RANGE;
        end else if (tree_root(r.a) == tree_root(r.b)) begin
          n_joined++;
          uv = common_ancestor(r.a, r.b);
          res.same_tree = 1'b1;
          res.ancestor = NW'(uv);
          if (tree_root(r.s) == tree_root(r.a)) begin
            us = common_ancestor(r.a, r.s);
            vs = common_ancestor(r.b, r.s);
            res.on_path = (uv == r.s) || (us == uv && vs == r.s) ||
                          (vs == uv && us == r.s);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: present the next pending item, predict each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_item.valid <= 1'b0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        expected_res = {expected_res, answer_request(on_wire)};
        accepted_n++;
      end
      if (!in_item.valid || in_item.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pending_reqs.pop_front();
          in_item.valid    <= 1'b1;
          in_item.req_type <= on_wire.req;
          in_item.node_a   <= on_wire.a;
          in_item.node_b   <= on_wire.b;
          in_item.node_s   <= on_wire.s;
        end else begin
          in_item.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, a long hold on request, and the checks.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_item.ready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
    end else begin
      if (out_item.valid && out_item.ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d anc %0d onp %0b same %0b",
                   $time, out_item.status, out_item.ancestor, out_item.on_path,
                   out_item.same_tree);
          errors++;
        end else begin
          lca_res_t exp_r;
          exp_r = expected_res.pop_front();
          checked_n++;
          if (out_item.status !== exp_r.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_r.status,
                     out_item.status);
            errors++;
          end
          if (out_item.ancestor !== exp_r.ancestor) begin
            $display("%0t: ancestor expected %0d got %0d", $time, exp_r.ancestor,
                     out_item.ancestor);
            errors++;
          end
          if (out_item.on_path !== exp_r.on_path) begin
            $display("%0t: on_path expected %0b got %0b", $time, exp_r.on_path,
                     out_item.on_path);
            errors++;
          end
          if (out_item.same_tree !== exp_r.same_tree) begin
            $display("%0t: same_tree expected %0b got %0b", $time, exp_r.same_tree,
                     out_item.same_tree);
            errors++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt <= 400;
        out_item.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_item.ready <= 1'b0;
      end else begin
        out_item.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send(req_t rq, int a, int b, int s);
    lca_req_t item;
    item = '{req: rq, a: NW'(a), b: NW'(b), s: NW'(s)};
    pending_reqs = {pending_reqs, item};
    pushed_n++;
  endtask

  // Hold the sender back until every owed result has come, then settle.
  task automatic drain();
    while (accepted_n != pushed_n || expected_res.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_count(int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CW'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_count = CW'(value);
    tables_built = 1'b0;
  endtask

  // One phase: set the count, load a forest, build, then query it.
  task automatic run_forest(int cnt, int n_edges, int n_q, bit long_hold);
    int a;
    int b;
    int s;
    int k;
    write_count(cnt);
    if (cnt < 1) cnt = 1;
    send(REQ_QUERY, 0, 0, 0);      // stale tables or none at all
    if (edges_held >= 350) n_edges = 2;
    for (int e = 0; e < n_edges; e++) begin
      k = $urandom_range(99);
      if (k < 8) begin
        send(REQ_ADD, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
      end else if (k < 25 || cnt < 2) begin
        send(REQ_ADD, $urandom_range(cnt - 1), $urandom_range(cnt - 1), $urandom_range(1023));
      end else begin
        a = $urandom_range(cnt - 1, 1);
        send(REQ_ADD, a, $urandom_range(a - 1), $urandom_range(1023));
      end
    end
    send(REQ_BUILD, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
    if (long_hold) begin
      drain();
      hold_req++;
    end
    for (int q = 0; q < n_q; q++) begin
      a = $urandom_range(cnt - 1);
      b = $urandom_range(cnt - 1);
      k = $urandom_range(99);
      s = (k < 20) ? a : (k < 35) ? b : $urandom_range(cnt - 1);
      k = $urandom_range(99);
      if (k < 3) begin
        send(REQ_NONE, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
      end else if (k < 8) begin
        send(REQ_QUERY, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
      end else begin
        send(REQ_QUERY, a, b, s);
      end
    end
    drain();
  endtask

  initial begin
    int cnt;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_item.valid = 1'b0;
    in_item.req_type = REQ_NONE;
    in_item.node_a = '0;
    in_item.node_b = '0;
    in_item.node_s = '0;
    out_item.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_count = CW'(MAX_NODES);
    edges_held = 0;
    tables_built = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full count, the widest node numbers, every request kind.
    send(REQ_QUERY, 1023, 0, 512);                 // before any build
    send(REQ_ADD, 0, 1023, 0);
    send(REQ_ADD, 1023, 512, 0);
    send(REQ_ADD, 5, 1000, 0);
    send(REQ_ADD, 512, 0, 0);                      // closes a cycle
    send(REQ_ADD, 7, 7, 0);                        // self loop
    send(REQ_QUERY, 1023, 0, 512);                 // edge added since
    send(REQ_BUILD, 1023, 1023, 1023);
    send(REQ_QUERY, 512, 0, 1023);
    send(REQ_QUERY, 1023, 1023, 1023);
    send(REQ_QUERY, 0, 512, 5);                    // s in another tree
    send(REQ_QUERY, 1000, 512, 0);                 // different trees
    send(REQ_QUERY, 1000, 5, 1000);
    send(REQ_QUERY, 682, 341, 682);
    send(REQ_NONE, 1023, 1023, 1023);
    drain();
    write_count(2047);                             // clamps to the maximum
    send(REQ_BUILD, 0, 0, 0);
    send(REQ_QUERY, 1023, 512, 0);
    drain();
    write_count(0);                                // acts as one node
    send(REQ_ADD, 0, 1, 0);                        // endpoint out of range
    send(REQ_ADD, 0, 0, 0);
    send(REQ_BUILD, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 0);
    send(REQ_QUERY, 0, 0, 1);                      // node out of range
    drain();

    // Random forests through the idling phases.
    for (int ph = 0; ph < 28; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      k_cnt: begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(64, 33) : $urandom_range(24, 2);
        if (ph == 5) cnt = 1;
      end
      run_forest(cnt, $urandom_range(cnt + 3, 2), $urandom_range(25, 15), ph == 4);
    end

    // Fill the edge store to the brim, then build over a small count.
    send_idle_pct = 0;
    recv_stall_pct = 20;
    write_count(8);
    while (edges_held < EDGE_CAP) begin
      for (int e = edges_held; e < EDGE_CAP; e++)
        send(REQ_ADD, $urandom_range(7), $urandom_range(7), 0);
      drain();
    end
    send(REQ_ADD, 1, 2, 0);                        // store full
    send(REQ_QUERY, 1, 2, 3);
    send(REQ_BUILD, 0, 0, 0);
    for (int q = 0; q < 10; q++)
      send(REQ_QUERY, $urandom_range(7), $urandom_range(7), $urandom_range(7));
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d items, %0d results checked: %0d builds, %0d queries",
             accepted_n, checked_n, n_builds, n_queries);
    $display("%0d queries joined a tree, edge store ended with %0d edges",
             n_joined, edges_held);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/tlq_pkg.sv
rtl/tlq_if.sv
rtl/tlq_ctrl.sv
rtl/tlq_dpath.sv
rtl/tree_lca_path_query_unit.sv
verif/tb_tree_lca_path_query_unit.sv
